// ----- design/gda_pkg.sv -----
package gda_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int COUNT_W  = 16;
   localparam int SERIAL_W = 22;
   localparam int YIB_W    = 9;   // year within a 400-year block

   typedef logic [YEAR_W-1:0]   year_type;
   typedef logic [MONTH_W-1:0]  month_type;
   typedef logic [DAY_W-1:0]    day_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [SERIAL_W-1:0] serial_type;
   typedef logic [YIB_W-1:0]    yib_type;
   typedef logic [2:0]          opcode_type;

   localparam opcode_type OP_VALIDATE = 3'd0;
   localparam opcode_type OP_NEXT     = 3'd1;
   localparam opcode_type OP_ADD      = 3'd2;
   localparam opcode_type OP_SUB      = 3'd3;
   localparam opcode_type OP_DIFF     = 3'd4;

   localparam year_type   MAX_YEAR       = 14'd9999;
   localparam year_type   MIN_YEAR_RESET = 14'd1601;
   localparam year_type   BLOCK_YEARS    = 14'd400;
   localparam month_type  LAST_MONTH     = 4'd12;
   // days in one 400-year cycle, and the serial day of 9999-12-31
   localparam serial_type BLOCK_DAYS     = 22'd146097;
   localparam serial_type LAST_SERIAL    = 22'd3652424;

   typedef struct packed {
      opcode_type opcode;
      day_type    first_day;
      month_type  first_month;
      year_type   first_year;
      day_type    second_day;
      month_type  second_month;
      year_type   second_year;
      count_type  day_count;
   } req_type;

   typedef struct packed {
      day_type    result_day;
      month_type  result_month;
      year_type   result_year;
      logic       is_valid;
      serial_type days_between;
      logic       out_of_range;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BLK,
      ST_YEAR,
      ST_MON,
      ST_DAY,
      ST_SWAP,
      ST_DIFF,
      ST_NEG,
      ST_ADJ,
      ST_FBLK,
      ST_FYEAR,
      ST_FMON,
      ST_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic idle;
      logic done;
   } status_type;

   // year counted from the start of a 400-year cycle; year 0 of the cycle is leap
   function automatic logic leap_in_block(yib_type yr);
      return (yr[1:0] == 2'b00) && (yr != 9'd100) && (yr != 9'd200) && (yr != 9'd300);
   endfunction

   function automatic day_type month_len(month_type m, logic leap);
      day_type len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic serial_type year_len(logic leap);
      return leap ? 22'd366 : 22'd365;
   endfunction

   function automatic year_type year_sat(year_type y);
      return (y > MAX_YEAR) ? MAX_YEAR : y;
   endfunction

   function automatic month_type month_clamp(month_type m);
      month_type r;
      if (m == 4'd0) begin
         r = 4'd1;
      end else if (m > LAST_MONTH) begin
         r = LAST_MONTH;
      end else begin
         r = m;
      end
      return r;
   endfunction

endpackage

// ----- design/gda_engine.sv -----
module gda_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  gda_pkg::req_type     req,
   input  gda_pkg::year_type    min_year,
   input  logic                 out_ready,
   output gda_pkg::status_type  status,
   output gda_pkg::rsp_type     rsp
);
   import gda_pkg::*;

   state_type  state_ff, state_in;
   req_type    item_ff;
   year_type   rem_ff, rem_in;
   yib_type    cnt_ff, cnt_in;
   month_type  mi_ff, mi_in;
   month_type  cm_ff, cm_in;
   day_type    cd_ff, cd_in;
   serial_type acc_ff, acc_in;
   serial_type s1_ff, s1_in;
   year_type   ybase_ff, ybase_in;
   logic       sec_ff, sec_in;
   logic       neg_ff, neg_in;
   logic       oor_ff, oor_in;
   logic       valid_ff, valid_in;

   // shared add/subtract unit
   serial_type            ux, uy;
   logic                  usub;
   logic [SERIAL_W:0]     ures;
   serial_type            ures_val;
   logic                  ures_borrow;

   logic       leap_cur;
   logic       leap_chk;
   day_type    mlen_mi;
   day_type    mlen_cm;
   day_type    day_clamped;
   day_type    day_off;
   serial_type step_k;
   logic       rem_ge_blk;
   opcode_type op;

   assign op          = item_ff.opcode;
   assign leap_cur    = leap_in_block(cnt_ff);
   assign leap_chk    = leap_in_block(rem_ff[YIB_W-1:0]);
   assign mlen_mi     = month_len(mi_ff, leap_cur);
   assign mlen_cm     = month_len(cm_ff, leap_cur);
   assign rem_ge_blk  = (rem_ff >= BLOCK_YEARS);
   assign step_k      = (op == OP_NEXT) ? serial_type'(1) : serial_type'(item_ff.day_count);

   always_comb begin
      if (cd_ff == 5'd0) begin
         day_clamped = 5'd1;
      end else if (cd_ff > mlen_cm) begin
         day_clamped = mlen_cm;
      end else begin
         day_clamped = cd_ff;
      end
   end
   assign day_off = day_clamped - 5'd1;

   always_comb begin
      ux   = acc_ff;
      uy   = '0;
      usub = 1'b0;
      unique case (state_ff)
         ST_BLK:   uy = BLOCK_DAYS;
         ST_YEAR:  uy = year_len(leap_cur);
         ST_MON:   uy = serial_type'(mlen_mi);
         ST_DAY:   uy = serial_type'(day_off);
         ST_DIFF: begin
            uy   = s1_ff;
            usub = 1'b1;
         end
         ST_NEG: begin
            ux   = '0;
            uy   = acc_ff;
            usub = 1'b1;
         end
         ST_ADJ: begin
            uy   = step_k;
            usub = (op == OP_SUB);
         end
         ST_FBLK: begin
            uy   = BLOCK_DAYS;
            usub = 1'b1;
         end
         ST_FYEAR: begin
            uy   = year_len(leap_cur);
            usub = 1'b1;
         end
         ST_FMON: begin
            uy   = serial_type'(mlen_mi);
            usub = 1'b1;
         end
         default: begin
            uy   = '0;
         end
      endcase
   end

   assign ures        = usub ? ({1'b0, ux} - {1'b0, uy}) : ({1'b0, ux} + {1'b0, uy});
   assign ures_val    = ures[SERIAL_W-1:0];
   assign ures_borrow = ures[SERIAL_W];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req.opcode > OP_DIFF) ? ST_DONE : ST_BLK;
            end
         end
         ST_BLK: begin
            if (!rem_ge_blk) begin
               state_in = (op == OP_VALIDATE) ? ST_CHK : ST_YEAR;
            end
         end
         ST_YEAR:  if (cnt_ff == rem_ff[YIB_W-1:0]) state_in = ST_MON;
         ST_MON:   if (mi_ff == cm_ff) state_in = ST_DAY;
         ST_DAY: begin
            if (op == OP_DIFF) begin
               state_in = sec_ff ? ST_DIFF : ST_SWAP;
            end else begin
               state_in = ST_ADJ;
            end
         end
         ST_SWAP:  state_in = ST_BLK;
         ST_DIFF:  state_in = ST_NEG;
         ST_NEG:   state_in = ST_DONE;
         ST_ADJ:   state_in = ST_FBLK;
         ST_FBLK:  if (ures_borrow) state_in = ST_FYEAR;
         ST_FYEAR: if (ures_borrow) state_in = ST_FMON;
         ST_FMON:  if (ures_borrow || (mi_ff == LAST_MONTH)) state_in = ST_DONE;
         ST_CHK:   state_in = ST_DONE;
         ST_DONE:  if (out_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      mi_in    = mi_ff;
      cm_in    = cm_ff;
      cd_in    = cd_ff;
      acc_in   = acc_ff;
      s1_in    = s1_ff;
      ybase_in = ybase_ff;
      sec_in   = sec_ff;
      neg_in   = neg_ff;
      oor_in   = oor_ff;
      valid_in = valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               acc_in   = '0;
               oor_in   = 1'b0;
               valid_in = 1'b0;
               sec_in   = 1'b0;
               ybase_in = '0;
               // validity check looks at the raw year
               rem_in   = (req.opcode == OP_VALIDATE) ? req.first_year
                                                      : year_sat(req.first_year);
               cm_in    = month_clamp(req.first_month);
               cd_in    = req.first_day;
            end
         end
         ST_BLK: begin
            if (rem_ge_blk) begin
               rem_in = rem_ff - BLOCK_YEARS;
               acc_in = ures_val;
            end else begin
               cnt_in = '0;
            end
         end
         ST_YEAR: begin
            if (cnt_ff != rem_ff[YIB_W-1:0]) begin
               acc_in = ures_val;
               cnt_in = cnt_ff + 9'd1;
            end else begin
               mi_in  = 4'd1;
            end
         end
         ST_MON: begin
            if (mi_ff != cm_ff) begin
               acc_in = ures_val;
               mi_in  = mi_ff + 4'd1;
            end
         end
         ST_DAY:  acc_in = ures_val;
         ST_SWAP: begin
            s1_in  = acc_ff;
            acc_in = '0;
            rem_in = year_sat(item_ff.second_year);
            cm_in  = month_clamp(item_ff.second_month);
            cd_in  = item_ff.second_day;
            sec_in = 1'b1;
         end
         ST_DIFF: begin
            acc_in = ures_val;
            neg_in = ures_borrow;
         end
         ST_NEG: begin
            if (neg_ff) begin
               acc_in = ures_val;
            end
         end
         ST_ADJ: begin
            ybase_in = '0;
            if (op == OP_SUB) begin
               if (ures_borrow) begin
                  oor_in = 1'b1;
                  acc_in = '0;
               end else begin
                  acc_in = ures_val;
               end
            end else if (ures_val > LAST_SERIAL) begin
               oor_in = 1'b1;
               acc_in = LAST_SERIAL;
            end else begin
               acc_in = ures_val;
            end
         end
         ST_FBLK: begin
            if (!ures_borrow) begin
               acc_in   = ures_val;
               ybase_in = ybase_ff + BLOCK_YEARS;
            end else begin
               cnt_in   = '0;
            end
         end
         ST_FYEAR: begin
            if (!ures_borrow) begin
               acc_in = ures_val;
               cnt_in = cnt_ff + 9'd1;
            end else begin
               mi_in  = 4'd1;
            end
         end
         ST_FMON: begin
            if (!ures_borrow && (mi_ff != LAST_MONTH)) begin
               acc_in = ures_val;
               mi_in  = mi_ff + 4'd1;
            end
         end
         ST_CHK: begin
            valid_in = (item_ff.first_year >= min_year) && (item_ff.first_year <= MAX_YEAR) &&
                       (item_ff.first_month >= 4'd1) && (item_ff.first_month <= LAST_MONTH) &&
                       (item_ff.first_day >= 5'd1) &&
                       (item_ff.first_day <= month_len(item_ff.first_month, leap_chk));
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && (state_ff == ST_IDLE)) begin
         item_ff <= req;
      end
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      mi_ff    <= mi_in;
      cm_ff    <= cm_in;
      cd_ff    <= cd_in;
      acc_ff   <= acc_in;
      s1_ff    <= s1_in;
      ybase_ff <= ybase_in;
      sec_ff   <= sec_in;
      neg_ff   <= neg_in;
      oor_ff   <= oor_in;
      valid_ff <= valid_in;
   end

   // result assembly
   always_comb begin
      rsp = '0;
      unique case (op)
         OP_VALIDATE: rsp.is_valid = valid_ff;
         OP_NEXT, OP_ADD, OP_SUB: begin
            rsp.result_day   = acc_ff[DAY_W-1:0] + 5'd1;
            rsp.result_month = mi_ff;
            rsp.result_year  = ybase_ff + year_type'(cnt_ff);
            rsp.out_of_range = oor_ff;
         end
         OP_DIFF:     rsp.days_between = acc_ff;
         default:     rsp = '0;
      endcase
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);

   a_year_in_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FYEAR) |-> (cnt_ff < YIB_W'(BLOCK_YEARS)))
      else $error("year counter left its 400-year cycle");

   a_serial_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FBLK) |-> (acc_ff <= LAST_SERIAL))
      else $error("serial day past the last supported date");

   a_month_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MON) |-> (mi_ff <= cm_ff))
      else $error("month walk ran past the target month");

   a_result_date: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && ((op == OP_NEXT) || (op == OP_ADD) || (op == OP_SUB)))
      |-> ((mi_ff >= 4'd1) && (mi_ff <= LAST_MONTH) && (acc_ff < serial_type'(31))))
      else $error("result date out of shape");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && !out_ready) |=> (state_ff == ST_DONE))
      else $error("finished result dropped while output was full");

endmodule

// ----- design/gregorian_date_arithmetic.sv -----
// channel   dir  handshake               payload
// req       in   req_valid / req_stall   req_data  (gda_pkg::req_type)
// rsp       out  rsp_valid / rsp_stall   rsp_data  (gda_pkg::rsp_type)
// csr       in   csr_valid / csr_ready   csr_data  (min_year, 14 bits)
//
// One item at a time through a single 22-bit add/subtract unit: a date becomes a
// serial day by stepping 400-year cycles, then single years, then months, then the day.
// Difference converts the two dates back to back.
// Synchronous reset returns the sequencer to idle and min_year to 1601.
// A finished item sits in the output register; the next item is taken meanwhile.
module gregorian_date_arithmetic (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gda_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gda_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  gda_pkg::year_type csr_data
);
   import gda_pkg::*;

   year_type   min_year_ff, min_year_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;
   status_type status;
   rsp_type    result;
   logic       start;
   logic       out_ready;

   assign csr_ready = 1'b1;
   assign req_stall = !status.idle;
   assign start     = req_valid && !req_stall;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   gda_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .min_year  (min_year_ff),
      .out_ready (out_ready),
      .status    (status),
      .rsp       (result)
   );

   always_comb begin
      min_year_in = (csr_valid && csr_ready) ? csr_data : min_year_ff;
      if (status.done && out_ready) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_year_ff  <= MIN_YEAR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_year_ff  <= min_year_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.done && out_ready) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
